[hdl/bpo_pkg.sv]
// shared types and constants for the box pairwise overlap checker
package bpo_pkg;

  localparam int DIM_W    = 3;
  localparam int ORIGIN_W = 32;
  localparam int EXTENT_W = 31;
  localparam int COORD_W  = ORIGIN_W + EXTENT_W;
  localparam int PAIR_W   = 6;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_SCAN,
    ST_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_READ,
    SC_CMP
  } scan_state_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

[hdl/box_pairwise_overlap_check.sv]
// top level of the box pairwise overlap checker
//
// Boxes arrive on the slave stream one coordinate per request, box by box and
// dimension by dimension: tdata carries origin and extent, tlast marks the
// final coordinate of the set. Each coordinate that fits in the store is
// written to it, so loading runs at one request per cycle while s_tready is high.
// After the request with tlast the block stops taking requests, divides the
// coordinate count by the dimension count (bit-serial) and then scans the box
// pairs in order until the first overlapping pair, comparing one dimension at
// a time and reading both boxes of a pair through two copies of the store.
// A store overflow skips the divide and answers with STATUS_OVERFLOW; a count
// that the dimension count does not divide answers with STATUS_BAD_COUNT.
// One result leaves on the master stream per set; it sits in an output
// register, so loading of the next set starts while the result waits for
// tready. A later set's result waits in the block until that register frees.
// dimension_count is written through dimension_count_we / _wdata, reset 2.
// Reset empties the set and drops any pending result; the store needs no
// clearing since only coordinates of the current set are read.
module box_pairwise_overlap_check
  import bpo_pkg::*;
#(
  parameter int MAX_BOXES = 64,
  parameter int MAX_DIMS  = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,   // origin[31:0], extent[62:32], zero[63]
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // no_overlap[0], pair_first[6:1],
                                      // pair_second[12:7], status[14:13], zero[15]
  input  logic             dimension_count_we,
  input  logic [DIM_W-1:0] dimension_count_wdata
);

  localparam int DEPTH = MAX_BOXES * MAX_DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  top_state_t       state, state_next;
  logic [CW-1:0]    item_count, item_count_next;
  logic             overflow_seen, overflow_next;
  logic [DIM_W-1:0] dimension_count;
  logic [DIM_W-1:0] dims_eff, dims_lat;
  logic [CW-1:0]    count_final;

  logic                res_ok, res_ok_next;
  logic [PAIR_W-1:0]   res_first, res_first_next, res_second, res_second_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                out_load;

  logic             in_acc, store_ok, wr_en;
  logic             div_start, div_done;
  logic [CW-1:0]    div_quot;
  logic [DIM_W-1:0] div_rem;
  logic             scan_start;
  logic [CW-1:0]    scan_boxes;
  logic [AW-1:0]    addr_a, addr_b, scan_first, scan_second;
  logic [COORD_W-1:0] rdata_a, rdata_b, wdata;
  scan_stat_t       scan_stat;

  assign s_tready = (state == ST_LOAD);
  assign in_acc   = s_tvalid & s_tready;
  assign store_ok = item_count < CW'(DEPTH);
  assign wr_en    = in_acc & store_ok;
  assign wdata    = s_tdata[COORD_W-1:0];
  assign count_final = store_ok ? item_count + CW'(1) : item_count;

  always_comb begin
    if (dimension_count == '0) begin
      dims_eff = DIM_W'(1);
    end else if (32'(dimension_count) > MAX_DIMS) begin
      dims_eff = DIM_W'(MAX_DIMS);
    end else begin
      dims_eff = dimension_count;
    end
  end

  // two copies of the store so both boxes of a pair read in the same cycle
  bpo_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH), .AW(AW)) u_store_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(item_count)),
    .wdata (wdata),
    .raddr (addr_a),
    .rdata (rdata_a)
  );

  bpo_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH), .AW(AW)) u_store_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(item_count)),
    .wdata (wdata),
    .raddr (addr_b),
    .rdata (rdata_b)
  );

  bpo_divmod #(.CW(CW)) u_divmod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (count_final),
    .divisor   (dims_eff),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign scan_boxes = div_quot;

  bpo_scan #(.AW(AW), .CW(CW)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .dims        (dims_lat),
    .boxes       (scan_boxes),
    .addr_a      (addr_a),
    .addr_b      (addr_b),
    .rdata_a     (rdata_a),
    .rdata_b     (rdata_b),
    .pair_first  (scan_first),
    .pair_second (scan_second),
    .stat        (scan_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_LOAD;
      item_count      <= '0;
      overflow_seen   <= 1'b0;
      dimension_count <= DIM_W'(2);
      m_tvalid        <= 1'b0;
    end else begin
      state         <= state_next;
      item_count    <= item_count_next;
      overflow_seen <= overflow_next;
      if (dimension_count_we) begin
        dimension_count <= dimension_count_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_ok     <= res_ok_next;
    res_first  <= res_first_next;
    res_second <= res_second_next;
    res_status <= res_status_next;
    if (in_acc && s_tlast) begin
      dims_lat <= dims_eff;
    end
    if (out_load) begin
      m_tdata <= {1'b0, res_status, res_second, res_first, res_ok};
    end
  end

  always_comb begin
    state_next      = state;
    item_count_next = item_count;
    overflow_next   = overflow_seen;
    res_ok_next     = res_ok;
    res_first_next  = res_first;
    res_second_next = res_second;
    res_status_next = res_status;
    div_start       = 1'b0;
    scan_start      = 1'b0;
    out_load        = 1'b0;
    unique case (state)
      ST_LOAD: begin
        if (in_acc) begin
          if (s_tlast) begin
            item_count_next = '0;
            overflow_next   = 1'b0;
            res_ok_next     = 1'b0;
            res_first_next  = '0;
            res_second_next = '0;
            if (overflow_seen || !store_ok) begin
              res_status_next = STATUS_OVERFLOW;
              state_next      = ST_EMIT;
            end else begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end else begin
            item_count_next = count_final;
            overflow_next   = overflow_seen | ~store_ok;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_rem != '0) begin
            res_status_next = STATUS_BAD_COUNT;
            state_next      = ST_EMIT;
          end else begin
            scan_start = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          res_status_next = STATUS_OK;
          res_ok_next     = ~scan_stat.found;
          res_first_next  = scan_stat.found ? PAIR_W'(scan_first) : '0;
          res_second_next = scan_stat.found ? PAIR_W'(scan_second) : '0;
          state_next      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

[hdl/bpo_ram.sv]
// generic single write port, single read port ram with registered read
module bpo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/bpo_divmod.sv]
// bit-serial restoring divider: coordinate count over dimension count
module bpo_divmod
  import bpo_pkg::*;
#(
  parameter int CW = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CW-1:0]    dividend,
  input  logic [DIM_W-1:0] divisor,
  output logic             done,
  output logic [CW-1:0]    quotient,
  output logic [DIM_W-1:0] remainder
);

  localparam int SW = $clog2(CW + 1);

  logic             busy;
  logic [SW-1:0]    step;
  logic [DIM_W-1:0] dvs;
  logic [DIM_W:0]   trial;
  logic             ge;

  // shift next dividend bit into the partial remainder
  assign trial = {remainder, quotient[CW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= SW'(CW);
      end else if (busy) begin
        step <= step - SW'(1);
        if (step == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[CW-2:0], ge};
      remainder <= ge ? DIM_W'(trial - {1'b0, dvs}) : trial[DIM_W-1:0];
    end
  end

endmodule

[hdl/bpo_scan.sv]
// pair scan: walks box pairs in order, reads both boxes a dimension at a time
module bpo_scan
  import bpo_pkg::*;
#(
  parameter int AW = 8,
  parameter int CW = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIM_W-1:0]   dims,
  input  logic [CW-1:0]      boxes,
  output logic [AW-1:0]      addr_a,
  output logic [AW-1:0]      addr_b,
  input  logic [COORD_W-1:0] rdata_a,
  input  logic [COORD_W-1:0] rdata_b,
  output logic [AW-1:0]      pair_first,
  output logic [AW-1:0]      pair_second,
  output scan_stat_t         stat
);

  scan_state_t      state, state_next;
  logic [AW-1:0]    box_i, box_i_next, box_j, box_j_next;
  logic [CW-1:0]    base_a, base_a_next, base_b, base_b_next;
  logic [DIM_W-1:0] dim, dim_next;
  scan_stat_t       stat_next;

  logic signed [ORIGIN_W:0] org_a, org_b, end_a, end_b;
  logic                     dim_overlap;

  assign addr_a = AW'(base_a + CW'(dim));
  assign addr_b = AW'(base_b + CW'(dim));

  // sums at 33 bits so they never wrap
  assign org_a = {rdata_a[ORIGIN_W-1], rdata_a[ORIGIN_W-1:0]};
  assign org_b = {rdata_b[ORIGIN_W-1], rdata_b[ORIGIN_W-1:0]};
  assign end_a = org_a + signed'({2'b00, rdata_a[COORD_W-1:ORIGIN_W]});
  assign end_b = org_b + signed'({2'b00, rdata_b[COORD_W-1:ORIGIN_W]});
  assign dim_overlap = (end_a > org_b) && (end_b > org_a);

  assign pair_first  = box_i;
  assign pair_second = box_j;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      stat  <= '0;
    end else begin
      state <= state_next;
      stat  <= stat_next;
    end
  end

  always_ff @(posedge clk) begin
    box_i  <= box_i_next;
    box_j  <= box_j_next;
    base_a <= base_a_next;
    base_b <= base_b_next;
    dim    <= dim_next;
  end

  always_comb begin
    state_next  = state;
    box_i_next  = box_i;
    box_j_next  = box_j;
    base_a_next = base_a;
    base_b_next = base_b;
    dim_next    = dim;
    stat_next   = '{done: 1'b0, found: stat.found};
    unique case (state)
      SC_IDLE: begin
        if (start) begin
          box_i_next      = '0;
          box_j_next      = AW'(1);
          base_a_next     = '0;
          base_b_next     = CW'(dims);
          dim_next        = '0;
          stat_next.found = 1'b0;
          if (boxes < CW'(2)) begin
            stat_next.done = 1'b1;
          end else begin
            state_next = SC_READ;
          end
        end
      end
      SC_READ: begin
        state_next = SC_CMP;
      end
      SC_CMP: begin
        if (dim_overlap) begin
          if ((DIM_W + 1)'(dim) + (DIM_W + 1)'(1) < {1'b0, dims}) begin
            dim_next   = dim + DIM_W'(1);
            state_next = SC_READ;
          end else begin
            stat_next  = '{done: 1'b1, found: 1'b1};
            state_next = SC_IDLE;
          end
        end else begin
          dim_next = '0;
          if (CW'(box_j) + CW'(1) < boxes) begin
            box_j_next  = box_j + AW'(1);
            base_b_next = base_b + CW'(dims);
            state_next  = SC_READ;
          end else if (CW'(box_i) + CW'(2) < boxes) begin
            // next first box, second box right after it
            box_i_next  = box_i + AW'(1);
            box_j_next  = box_i + AW'(2);
            base_a_next = base_a + CW'(dims);
            base_b_next = base_a + CW'(dims) + CW'(dims);
            state_next  = SC_READ;
          end else begin
            stat_next.done = 1'b1;
            state_next     = SC_IDLE;
          end
        end
      end
      default: state_next = SC_IDLE;
    endcase
  end

endmodule
